@@ rtl/core/ctf_pkg.sv @@
// Shared constants, register codes and the CORDIC angle table of the tilt filter.
package ctf_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned ANGLE_W       = 30;
  localparam int unsigned RATE_W        = 25;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned STEP_GAIN_W   = 24;
  localparam int unsigned RATE_GAIN_W   = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RATE_GAIN = 2'd2;

  // Register reset values
  localparam logic [WEIGHT_W-1:0]    GYRO_WEIGHT_RST    = 16'd64225;
  localparam logic [STEP_GAIN_W-1:0] GYRO_STEP_GAIN_RST = 24'd64000;
  localparam logic [RATE_GAIN_W-1:0] GYRO_RATE_GAIN_RST = 16'd500;

  // CORDIC
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_TABLE_LEN   = 24;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam int unsigned ATAN_W           = 22;
  localparam int unsigned CORDIC_PRESHIFT  = 14;
  localparam int unsigned MAG_W            = SAMPLE_W + 1;
  localparam int unsigned CORDIC_W         = MAG_W + CORDIC_PRESHIFT + 2;
  localparam int unsigned TILT_W           = 25;

  // Shared multiplier
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/ctf_in_if.sv @@
// Sample channel: accelerometer X and Z and gyro Y with valid/ready.
interface ctf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_z;
  logic signed [ctf_pkg::SAMPLE_W-1:0] gyro_y;

  modport source (output valid, output accel_x, output accel_z, output gyro_y, input ready);
  modport sink   (input valid, input accel_x, input accel_z, input gyro_y, output ready);
endinterface

@@ rtl/core/ctf_out_if.sv @@
// Result channel: filtered angle and gyro rate with valid/ready.
interface ctf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ctf_pkg::ANGLE_W-1:0] tilt_angle;
  logic signed [ctf_pkg::RATE_W-1:0]  angular_rate;

  modport source (output valid, output tilt_angle, output angular_rate, input ready);
  modport sink   (input valid, input tilt_angle, input angular_rate, output ready);
endinterface

@@ rtl/core/ctf_cfg_if.sv @@
// Configuration write channel: register index and write data with valid/ready.
interface ctf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ctf_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [ctf_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/core/ctf_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle through variable shifts of x and y.
module ctf_cordic #(
  parameter int unsigned STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ctf_pkg::MAG_W-1:0]          mag_x_i,
  input  logic [ctf_pkg::MAG_W-1:0]          mag_z_i,
  output logic                                done_o,
  output logic signed [ctf_pkg::TILT_W-1:0]  angle_o
);

  localparam int unsigned Iters = (STEPS < ctf_pkg::ATAN_TABLE_LEN) ? STEPS
                                                                     : ctf_pkg::ATAN_TABLE_LEN;
  localparam int unsigned CntW  = $clog2(Iters);
  localparam logic [CntW-1:0] LastCnt = CntW'(Iters - 1);

  logic signed [ctf_pkg::CORDIC_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ctf_pkg::TILT_W-1:0]   z_q, z_d, ang;
  logic [CntW-1:0]                     cnt_q, cnt_d;
  logic                                busy_q, busy_d, done_q, done_d;

  // Shift the current vector and fetch this step's angle
  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    ang = signed'(ctf_pkg::TILT_W'(ctf_pkg::atan_q16(ctf_pkg::ATAN_IDX_W'(cnt_q))));
  end

  // Load on start, rotate towards the x axis while busy
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = signed'({2'b00, mag_z_i, ctf_pkg::CORDIC_PRESHIFT'(0)});
      y_d    = signed'({2'b00, mag_x_i, ctf_pkg::CORDIC_PRESHIFT'(0)});
      z_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - ang;
      end
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

@@ rtl/core/ctf_mul.sv @@
// Shared signed multiplier with a registered product.
module ctf_mul (
  input  logic                                 clk_i,
  input  logic signed [ctf_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [ctf_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [ctf_pkg::MUL_P_W-1:0]  prod_o
);

  logic signed [ctf_pkg::MUL_P_W-1:0] prod_q, prod_d;

  // Form the full-width product
  always_comb begin
    prod_d = ctf_pkg::MUL_P_W'(a_i) * ctf_pkg::MUL_P_W'(b_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/core/complementary_tilt_filter.sv @@
// Top level of the complementary tilt filter: sequencer, config registers and angle state.
// The iterative CORDIC runs CORDIC_STEPS micro-rotations (capped at 24) per accepted sample.
// A new sample is taken only in the idle state, after the previous one has passed through
// the CORDIC and four passes through the one shared multiplier, three of them after it.
// A result waits in the output register while the next sample is taken.
// Reset clears the angle to zero and loads the default weight and gains.
module complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctf_in_if.sink      in_i,
  ctf_out_if.source   res_o,
  ctf_cfg_if.sink     cfg_i
);

  localparam int unsigned PW = ctf_pkg::MUL_P_W;
  localparam int unsigned AW = ctf_pkg::ANGLE_W;
  localparam int unsigned RW = ctf_pkg::RATE_W;
  localparam int unsigned StepW = 33;

  localparam logic signed [PW-1:0] RateMax  = (PW'(1) <<< (RW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] RateMin  = -(PW'(1) <<< (RW - 1));
  localparam logic signed [PW-1:0] AngleMax = (PW'(1) <<< (AW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] AngleMin = -(PW'(1) <<< (AW - 1));
  localparam logic signed [PW-1:0] StepRnd  = PW'(128);
  localparam logic signed [PW-1:0] AccRnd   = PW'(32768);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CORDIC   = 3'd1;
  localparam logic [2:0] S_MUL_STEP = 3'd2;
  localparam logic [2:0] S_STEP_SUM = 3'd3;
  localparam logic [2:0] S_MUL_GYRO = 3'd4;
  localparam logic [2:0] S_MUL_ACC  = 3'd5;
  localparam logic [2:0] S_ADD      = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [ctf_pkg::WEIGHT_W-1:0]    weight_q;
  logic [ctf_pkg::STEP_GAIN_W-1:0] step_gain_q;
  logic [ctf_pkg::RATE_GAIN_W-1:0] rate_gain_q;

  // Sample and working registers
  logic signed [ctf_pkg::SAMPLE_W-1:0] ax_q, az_q, gy_q;
  logic signed [ctf_pkg::TILT_W-1:0]   tilt_q;
  logic signed [RW-1:0]                rate_q, out_rate_q;
  logic signed [ctf_pkg::MUL_A_W-1:0]  sum_q;
  logic signed [PW-1:0]                acc_q;
  logic signed [AW-1:0]                angle_q;
  logic                                out_valid_q;
  logic                                cordic_busy_seen_q;

  logic in_acc, out_free;
  logic signed [ctf_pkg::MAG_W-1:0] ax_e, az_e;
  logic [ctf_pkg::MAG_W-1:0]        mag_x, mag_z;
  logic                             cordic_done;
  logic signed [ctf_pkg::TILT_W-1:0] cordic_z, tilt_d;
  logic signed [ctf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ctf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]              prod, step_shr, acc_shr;
  logic signed [StepW-1:0]           step;
  logic [ctf_pkg::WEIGHT_W:0]        accel_weight;
  logic signed [RW-1:0]              rate_sat;
  logic signed [AW-1:0]              angle_sat;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || res_o.ready;

  // Magnitudes of the latched accelerometer samples
  always_comb begin
    ax_e  = ctf_pkg::MAG_W'(ax_q);
    az_e  = ctf_pkg::MAG_W'(az_q);
    mag_x = ax_e[ctf_pkg::MAG_W-1] ? unsigned'(-ax_e) : unsigned'(ax_e);
    mag_z = az_e[ctf_pkg::MAG_W-1] ? unsigned'(-az_e) : unsigned'(az_e);
  end

  ctf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CORDIC && state_d == S_CORDIC && !cordic_busy_seen_q),
    .mag_x_i (mag_x),
    .mag_z_i (mag_z),
    .done_o  (cordic_done),
    .angle_o (cordic_z)
  );

  // Kick the CORDIC once, on the first cycle of the CORDIC state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cordic_busy_seen_q <= 1'b0;
    end else begin
      cordic_busy_seen_q <= (state_q == S_CORDIC);
    end
  end

  // Apply quadrant sign; both accelerometer axes zero gives zero tilt
  always_comb begin
    if (ax_q == '0 && az_q == '0) begin
      tilt_d = '0;
    end else if (ax_q[ctf_pkg::SAMPLE_W-1] != az_q[ctf_pkg::SAMPLE_W-1]) begin
      tilt_d = -cordic_z;
    end else begin
      tilt_d = cordic_z;
    end
  end

  // Select multiplier operands for the current pass
  always_comb begin
    accel_weight = {1'b1, ctf_pkg::WEIGHT_W'(0)} - {1'b0, weight_q};
    case (state_q)
      S_MUL_STEP: begin
        mul_a = signed'(ctf_pkg::MUL_A_W'(step_gain_q));
        mul_b = ctf_pkg::MUL_B_W'(gy_q);
      end
      S_MUL_GYRO: begin
        mul_a = sum_q;
        mul_b = signed'(ctf_pkg::MUL_B_W'(weight_q));
      end
      S_MUL_ACC: begin
        mul_a = ctf_pkg::MUL_A_W'(tilt_q);
        mul_b = signed'(ctf_pkg::MUL_B_W'(accel_weight));
      end
      default: begin
        mul_a = ctf_pkg::MUL_A_W'(gy_q);
        mul_b = signed'(ctf_pkg::MUL_B_W'(rate_gain_q));
      end
    endcase
  end

  ctf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Round and saturate the product-derived values
  always_comb begin
    if (prod > RateMax) begin
      rate_sat = RW'(RateMax);
    end else if (prod < RateMin) begin
      rate_sat = RW'(RateMin);
    end else begin
      rate_sat = RW'(prod);
    end
    step_shr = (prod + StepRnd) >>> 8;
    step     = StepW'(step_shr);
    acc_shr  = acc_q >>> 16;
    if (acc_shr > AngleMax) begin
      angle_sat = AW'(AngleMax);
    end else if (acc_shr < AngleMin) begin
      angle_sat = AW'(AngleMin);
    end else begin
      angle_sat = AW'(acc_shr);
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_acc) state_d = S_CORDIC;
      S_CORDIC:   if (cordic_done) state_d = S_MUL_STEP;
      S_MUL_STEP: state_d = S_STEP_SUM;
      S_STEP_SUM: state_d = S_MUL_GYRO;
      S_MUL_GYRO: state_d = S_MUL_ACC;
      S_MUL_ACC:  state_d = S_ADD;
      S_ADD:      state_d = S_FINISH;
      S_FINISH:   if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control state, configuration, angle and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weight_q    <= ctf_pkg::GYRO_WEIGHT_RST;
      step_gain_q <= ctf_pkg::GYRO_STEP_GAIN_RST;
      rate_gain_q <= ctf_pkg::GYRO_RATE_GAIN_RST;
      angle_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          ctf_pkg::CFG_GYRO_WEIGHT:    weight_q    <= ctf_pkg::WEIGHT_W'(cfg_i.wdata);
          ctf_pkg::CFG_GYRO_STEP_GAIN: step_gain_q <= ctf_pkg::STEP_GAIN_W'(cfg_i.wdata);
          ctf_pkg::CFG_GYRO_RATE_GAIN: rate_gain_q <= ctf_pkg::RATE_GAIN_W'(cfg_i.wdata);
          default: ;
        endcase
      end
      if (state_q == S_FINISH && out_free) begin
        angle_q     <= angle_sat;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= in_i.accel_x;
      az_q <= in_i.accel_z;
      gy_q <= in_i.gyro_y;
    end
    if (state_q == S_CORDIC && cordic_done) begin
      tilt_q <= tilt_d;
      rate_q <= rate_sat;
    end
    if (state_q == S_STEP_SUM) begin
      sum_q <= ctf_pkg::MUL_A_W'(angle_q) + ctf_pkg::MUL_A_W'(step);
    end
    if (state_q == S_MUL_ACC) begin
      acc_q <= prod;
    end
    if (state_q == S_ADD) begin
      acc_q <= acc_q + prod + AccRnd;
    end
    if (state_q == S_FINISH && out_free) begin
      out_rate_q <= rate_q;
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign res_o.valid        = out_valid_q;
  assign res_o.tilt_angle   = angle_q;
  assign res_o.angular_rate = out_rate_q;

endmodule

@@ tb/sv/complementary_tilt_filter_test.sv @@
// Self-checking testbench of the complementary tilt filter: directed table, then random phases.
`timescale 1ns / 100ps

module complementary_tilt_filter_test;
  import ctf_pkg::*;

  localparam int CORDIC_ITER   = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = CORDIC_ITER + 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 242;

  localparam longint ANGLE_CEIL  = 64'sd536870911;
  localparam longint ANGLE_FLOOR = -64'sd536870912;
  localparam longint RATE_CEIL   = 64'sd16777215;
  localparam longint RATE_FLOOR  = -64'sd16777216;

  localparam logic signed [ANGLE_W-1:0] ANGLE_HI = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_LO = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [RATE_W-1:0]  RATE_HI  = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0]  RATE_LO  = {1'b1, {(RATE_W-1){1'b0}}};

  // Index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
  } filter_result_t;

  typedef struct {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       reg_index;
    logic [CFG_DATA_W-1:0]      reg_data;
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] az;
    logic signed [SAMPLE_W-1:0] gy;
    bit                         angle_known;
    logic signed [ANGLE_W-1:0]  angle;
    bit                         rate_known;
    logic signed [RATE_W-1:0]   rate;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ctf_in_if  in_bus ();
  ctf_out_if res_bus ();
  ctf_cfg_if cfg_bus ();

  complementary_tilt_filter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Register copies and angle state of the predictor
  logic [WEIGHT_W-1:0]    weight_q16;
  logic [STEP_GAIN_W-1:0] step_gain_q24;
  logic [RATE_GAIN_W-1:0] rate_gain_q16;
  longint                 angle_state;

  filter_result_t awaited_results[$];
  stim_row_t      directed_rows[$];

  int  mismatches;
  int  quiet_cycles;
  int  burst_left;
  bit  sender_bursty;
  int  sink_mode;
  int  sink_mode_left;
  int  sink_stall_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic longint atan_deg_q16(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // Work out the result of one sample and advance the stored angle
  function automatic filter_result_t advance_filter(input logic signed [SAMPLE_W-1:0] ax,
                                                    input logic signed [SAMPLE_W-1:0] az,
                                                    input logic signed [SAMPLE_W-1:0] gy);
    longint x, y, z, xs, ys, tilt, rate, gstep, acc, w;
    int i;
    filter_result_t r;
    tilt = 0;
    if (ax != 0 || az != 0) begin
      x = longint'(az);
      y = longint'(ax);
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      x = x * (64'sd1 << CORDIC_PRESHIFT);
      y = y * (64'sd1 << CORDIC_PRESHIFT);
      z = 0;
      // Vectoring rotation: drive y towards zero, accumulating the angle
      for (i = 0; i < CORDIC_ITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_deg_q16(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_deg_q16(i);
        end
      end
      tilt = ((ax < 0) != (az < 0)) ? -z : z;
    end
    rate = longint'(gy) * longint'(rate_gain_q16);
    if (rate > RATE_CEIL) rate = RATE_CEIL;
    if (rate < RATE_FLOOR) rate = RATE_FLOOR;
    gstep = (longint'(gy) * longint'(step_gain_q24) + 128) >>> 8;
    w = longint'(weight_q16);
    acc = w * (angle_state + gstep) + (65536 - w) * tilt + 32768;
    angle_state = acc >>> 16;
    if (angle_state > ANGLE_CEIL) angle_state = ANGLE_CEIL;
    if (angle_state < ANGLE_FLOOR) angle_state = ANGLE_FLOOR;
    r.angle = ANGLE_W'(angle_state);
    r.rate  = RATE_W'(rate);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample_word();
    logic [SAMPLE_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3, 4: begin
        mag = SAMPLE_W'($urandom_range(1, 200));
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic add_sample(input logic [SAMPLE_W-1:0] ax, input logic [SAMPLE_W-1:0] az,
                            input logic [SAMPLE_W-1:0] gy,
                            input bit angle_known, input logic signed [ANGLE_W-1:0] angle,
                            input bit rate_known, input logic signed [RATE_W-1:0] rate);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, reg_index: '0, reg_data: '0, ax: ax, az: az, gy: gy,
            angle_known: angle_known, angle: angle, rate_known: rate_known, rate: rate};
    directed_rows.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_WRITE, reg_index: idx, reg_data: data, ax: '0, az: '0, gy: '0,
            angle_known: 1'b0, angle: '0, rate_known: 1'b0, rate: '0};
    directed_rows.push_back(row);
  endtask

  // Drop valid and hold until every awaited result has been taken
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_GYRO_WEIGHT:    weight_q16    = data[WEIGHT_W-1:0];
      CFG_GYRO_STEP_GAIN: step_gain_q24 = data[STEP_GAIN_W-1:0];
      CFG_GYRO_RATE_GAIN: rate_gain_q16 = data[RATE_GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample beat, with an occasional gap between bursts
  task automatic send_sample(input logic [SAMPLE_W-1:0] ax, input logic [SAMPLE_W-1:0] az,
                             input logic [SAMPLE_W-1:0] gy,
                             input bit angle_known, input logic signed [ANGLE_W-1:0] angle,
                             input bit rate_known, input logic signed [RATE_W-1:0] rate);
    int gap;
    filter_result_t want;
    if (sender_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 30);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_bus.valid   <= 1'b1;
    in_bus.accel_x <= ax;
    in_bus.accel_z <= az;
    in_bus.gyro_y  <= gy;
    do @(posedge clk_i); while (!in_bus.ready);
    if (burst_left > 0) burst_left--;
    want = advance_filter(ax, az, gy);
    if (angle_known) want.angle = angle;
    if (rate_known) want.rate = rate;
    awaited_results.push_back(want);
  endtask

  task automatic log_mismatch(input string what, input filter_result_t want,
                              input logic signed [ANGLE_W-1:0] got_angle,
                              input logic signed [RATE_W-1:0] got_rate);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: angle exp %0d got %0d, rate exp %0d got %0d", $realtime, what,
               want.angle, got_angle, want.rate, got_rate);
  endtask

  // Stimulus: directed table, then random phases each under a fresh register setting
  initial begin
    int k;
    int phase;
    int n;
    stim_row_t row;

    add_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, '0, 1'b1, '0);
    add_sample(16'sd0, 16'sd0, 16'sd32767, 1'b0, '0, 1'b1, 25'sd16383500);
    add_sample(16'sd0, 16'sd0, -16'sd32768, 1'b0, '0, 1'b1, -25'sd16384000);
    add_sample(16'sd32767, 16'sd0, 16'sd0, 1'b0, '0, 1'b1, '0);
    add_sample(-16'sd32768, 16'sd0, 16'sd1, 1'b0, '0, 1'b0, '0);
    add_sample(16'sd0, 16'sd32767, -16'sd1, 1'b0, '0, 1'b0, '0);
    add_sample(16'sd0, -16'sd32768, 16'sd0, 1'b0, '0, 1'b0, '0);
    add_sample(16'sd32767, 16'sd32767, 16'sd100, 1'b0, '0, 1'b0, '0);
    add_sample(-16'sd32768, 16'sd32767, -16'sd100, 1'b0, '0, 1'b0, '0);
    add_sample(16'sd32767, -16'sd32768, 16'sd0, 1'b0, '0, 1'b0, '0);
    add_sample(-16'sd32768, -16'sd32768, 16'sd0, 1'b0, '0, 1'b0, '0);
    add_sample(16'sd1, -16'sd1, 16'sd0, 1'b0, '0, 1'b0, '0);
    add_sample(-16'sd1, 16'sd1, 16'sd0, 1'b0, '0, 1'b0, '0);
    // Accelerometer path only
    add_write(CFG_GYRO_WEIGHT, 24'h000000);
    add_sample(16'sd12000, -16'sd9000, 16'sd0, 1'b0, '0, 1'b0, '0);
    add_sample(-16'sd5, 16'sd16000, 16'sd0, 1'b0, '0, 1'b0, '0);
    // Largest gyro weight and gains: angle and rate both saturate
    add_write(CFG_GYRO_WEIGHT, 24'h00FFFF);
    add_write(CFG_GYRO_STEP_GAIN, 24'hFFFFFF);
    add_write(CFG_GYRO_RATE_GAIN, 24'h00FFFF);
    add_write(CFG_SPARE_INDEX, 24'hFFFFFF);
    add_sample(16'sd0, 16'sd0, 16'sd32767, 1'b1, ANGLE_HI, 1'b1, RATE_HI);
    add_sample(16'sd0, 16'sd0, -16'sd32768, 1'b1, ANGLE_LO, 1'b1, RATE_LO);
    add_sample(16'sd0, 16'sd0, -16'sd32768, 1'b1, ANGLE_LO, 1'b1, RATE_LO);
    // Zero gains, upper data bits above the weight dropped
    add_write(CFG_GYRO_WEIGHT, 24'hFF8000);
    add_write(CFG_GYRO_STEP_GAIN, 24'h000000);
    add_write(CFG_GYRO_RATE_GAIN, 24'h5A0000);
    add_sample(16'sd32767, 16'sd0, 16'sd32767, 1'b0, '0, 1'b1, '0);
    add_sample(-16'sd7, 16'sd3, -16'sd32768, 1'b0, '0, 1'b1, '0);
    // Back to the power-up setting
    add_write(CFG_GYRO_WEIGHT, {8'hC3, GYRO_WEIGHT_RST});
    add_write(CFG_GYRO_STEP_GAIN, GYRO_STEP_GAIN_RST);
    add_write(CFG_GYRO_RATE_GAIN, {8'hA5, GYRO_RATE_GAIN_RST});

    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.accel_x    <= '0;
    in_bus.accel_z    <= '0;
    in_bus.gyro_y     <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.reg_index <= '0;
    cfg_bus.wdata     <= '0;
    weight_q16    = GYRO_WEIGHT_RST;
    step_gain_q24 = GYRO_STEP_GAIN_RST;
    rate_gain_q16 = GYRO_RATE_GAIN_RST;
    angle_state   = 0;
    mismatches    = 0;
    burst_left    = 0;
    sender_bursty = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_WRITE) begin
        write_register(row.reg_index, row.reg_data);
      end else begin
        send_sample(row.ax, row.az, row.gy, row.angle_known, row.angle,
                    row.rate_known, row.rate);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Every third phase the sender never idles
      sender_bursty = (phase % 3 != 2);
      case ($urandom_range(0, 3))
        0: write_register(CFG_GYRO_WEIGHT, {8'($urandom), 16'h0000});
        1: write_register(CFG_GYRO_WEIGHT, {8'($urandom), 16'hFFFF});
        2: write_register(CFG_GYRO_WEIGHT, {8'($urandom), GYRO_WEIGHT_RST});
        default: write_register(CFG_GYRO_WEIGHT, 24'($urandom));
      endcase
      case ($urandom_range(0, 4))
        0: write_register(CFG_GYRO_STEP_GAIN, 24'h000000);
        1: write_register(CFG_GYRO_STEP_GAIN, 24'hFFFFFF);
        2, 3: write_register(CFG_GYRO_STEP_GAIN, 24'($urandom_range(0, 1 << 17)));
        default: write_register(CFG_GYRO_STEP_GAIN, 24'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_register(CFG_GYRO_RATE_GAIN, {8'($urandom), 16'h0000});
        1: write_register(CFG_GYRO_RATE_GAIN, {8'($urandom), 16'hFFFF});
        2: write_register(CFG_GYRO_RATE_GAIN, {8'($urandom), GYRO_RATE_GAIN_RST});
        default: write_register(CFG_GYRO_RATE_GAIN, 24'($urandom));
      endcase
      if ($urandom_range(0, 1) != 0) write_register(CFG_SPARE_INDEX, 24'($urandom));

      for (n = 0; n < PHASE_SAMPLES; n++) begin
        // Now and then hold off until the block has emptied
        if ($urandom_range(0, 199) == 0) wait_for_drain();
        send_sample(pick_sample_word(), pick_sample_word(), pick_sample_word(),
                    1'b0, '0, 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result receiver: stall on a pattern that changes mode at random
  always @(posedge clk_i) begin
    logic take;
    if (!rst_ni) begin
      sink_mode       = 0;
      sink_mode_left  = 0;
      sink_stall_left = 0;
      res_bus.ready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode      = $urandom_range(0, 3);
        sink_mode_left = $urandom_range(50, 400);
      end else begin
        sink_mode_left--;
      end
      case (sink_mode)
        0: take = 1'b1;
        1: take = ($urandom_range(0, 3) != 0);
        2: take = ($urandom_range(0, 3) == 0);
        default: begin
          if (sink_stall_left > 0) begin
            sink_stall_left--;
            take = 1'b0;
          end else begin
            take = 1'b1;
            if ($urandom_range(0, 7) == 0) sink_stall_left = $urandom_range(5, 30);
          end
        end
      endcase
      res_bus.ready <= take;
    end
  end

  // Compare each result beat with the oldest awaited result
  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (awaited_results.size() == 0) begin
        want = '{angle: 'x, rate: 'x};
        log_mismatch("result beat with none awaited", want, res_bus.tilt_angle,
                     res_bus.angular_rate);
      end else begin
        want = awaited_results.pop_front();
        if (want.angle !== res_bus.tilt_angle || want.rate !== res_bus.angular_rate)
          log_mismatch("result mismatch", want, res_bus.tilt_angle, res_bus.angular_rate);
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

@@ complementary_tilt_filter.f @@
rtl/core/ctf_pkg.sv
rtl/core/ctf_in_if.sv
rtl/core/ctf_out_if.sv
rtl/core/ctf_cfg_if.sv
rtl/core/ctf_cordic.sv
rtl/core/ctf_mul.sv
rtl/core/complementary_tilt_filter.sv
tb/sv/complementary_tilt_filter_test.sv
